### sv/prlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prlt_pkg
// Shared types and constants for the pump run-limit and lockout timer.
// ----------------------------------------------------------------------------
package prlt_pkg;

  // Field and register widths
  localparam int unsigned OpW       = 2;
  localparam int unsigned SecW      = 32;
  localparam int unsigned StatusW   = 16;
  localparam int unsigned RunW      = 16;
  localparam int unsigned LockoutW  = 15;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // Register reset values
  localparam logic [StatusW-1:0]  StatusPeriodRst  = 16'd60;
  localparam logic [RunW-1:0]     RunLimitRst      = 16'd10;
  localparam logic [LockoutW-1:0] LockoutPeriodRst = 15'd3600;

  // Operation codes carried by an input transaction
  typedef enum logic [OpW-1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } op_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_STATUS_PERIOD  = 2'd0,
    CFG_RUN_LIMIT      = 2'd1,
    CFG_LOCKOUT_PERIOD = 2'd2
  } cfg_idx_e;

  // Current configuration, handed to the timer core
  typedef struct packed {
    logic [StatusW-1:0]  status_interval;
    logic [RunW-1:0]     run_limit;
    logic [LockoutW-1:0] lockout_period;
  } cfg_t;

  // One result transaction
  typedef struct packed {
    logic            pump_running;
    logic            status_due;
    logic [SecW-1:0] idle_seconds;
    logic            lockout_active;
  } result_t;

endpackage

### sv/pump_run_limit_lockout_timer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pump_run_limit_lockout_timer_top
// Pump run-limit and lockout timer with valid/ready channels.
// ----------------------------------------------------------------------------
// Every transaction (one-second tick, start or stop) gives exactly one result.
// A transaction is held in the input register, is processed in a single
// pass of counter logic and lands in the result register, which offers its
// result; one transaction is taken every cycle while results are drained;
// only a stalled result register holds the flow. Configuration writes take
// effect on the next clock edge and belong to times when no transaction is
// in flight. Unused op code 3 leaves the state alone and reports it.
module pump_run_limit_lockout_timer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [prlt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [prlt_pkg::CfgDataW-1:0] cfg_wdata_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [prlt_pkg::OpW-1:0]      op_i,
  input  logic                          reservoir_empty_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          pump_running_o,
  output logic                          status_due_o,
  output logic [prlt_pkg::SecW-1:0]     idle_seconds_o,
  output logic                          lockout_active_o
);

  prlt_pkg::cfg_t    cfg;
  prlt_pkg::result_t res;
  prlt_pkg::result_t res_q;

  logic                     in_valid_q, in_valid_d;
  logic [prlt_pkg::OpW-1:0] op_q;
  logic                     empty_q;
  logic                     out_valid_q, out_valid_d;
  logic                     fire;

  prlt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  prlt_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (fire),
    .op_i              (op_q),
    .reservoir_empty_i (empty_q),
    .cfg_i             (cfg),
    .res_o             (res)
  );

  // Handshake: process when the result register is free or being drained
  assign fire        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || fire;
  assign in_valid_d  = in_ready_o ? in_valid_i : in_valid_q;
  assign out_valid_d = fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input payload register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q    <= op_i;
      empty_q <= reservoir_empty_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pump_running_o   = res_q.pump_running;
  assign status_due_o     = res_q.status_due;
  assign idle_seconds_o   = res_q.idle_seconds;
  assign lockout_active_o = res_q.lockout_active;

endmodule

### sv/prlt_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prlt_cfg_regs
// Configuration register file: status period, run limit and lockout period.
// ----------------------------------------------------------------------------
module prlt_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [prlt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [prlt_pkg::CfgDataW-1:0] cfg_wdata_i,
  output prlt_pkg::cfg_t                cfg_o
);

  prlt_pkg::cfg_t cfg_q, cfg_d;

  // Write decode; an index beyond the list is dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (prlt_pkg::cfg_idx_e'(cfg_idx_i))
        prlt_pkg::CFG_STATUS_PERIOD:
          cfg_d.status_interval = cfg_wdata_i[prlt_pkg::StatusW-1:0];
        prlt_pkg::CFG_RUN_LIMIT:
          cfg_d.run_limit = cfg_wdata_i[prlt_pkg::RunW-1:0];
        prlt_pkg::CFG_LOCKOUT_PERIOD:
          cfg_d.lockout_period = cfg_wdata_i[prlt_pkg::LockoutW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.status_interval <= prlt_pkg::StatusPeriodRst;
      cfg_q.run_limit       <= prlt_pkg::RunLimitRst;
      cfg_q.lockout_period  <= prlt_pkg::LockoutPeriodRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/prlt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prlt_core
// Timer state and its single-pass update for one tick, start or stop.
// ----------------------------------------------------------------------------
module prlt_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [prlt_pkg::OpW-1:0]  op_i,
  input  logic                      reservoir_empty_i,
  input  prlt_pkg::cfg_t            cfg_i,
  output prlt_pkg::result_t         res_o
);

  logic [prlt_pkg::SecW-1:0]     sec_q, sec_d;
  logic [prlt_pkg::SecW-1:0]     last_stop_q, last_stop_d;
  logic [prlt_pkg::StatusW-1:0]  status_q, status_d;
  logic [prlt_pkg::RunW-1:0]     run_q, run_d;
  logic [prlt_pkg::LockoutW-1:0] lockout_q, lockout_d;
  logic                          pump_q, pump_d;
  logic                          due;

  // Next state for the transaction in the input register
  always_comb begin
    sec_d       = sec_q;
    last_stop_d = last_stop_q;
    status_d    = status_q;
    run_d       = run_q;
    lockout_d   = lockout_q;
    pump_d      = pump_q;
    due         = 1'b0;

    unique case (prlt_pkg::op_e'(op_i))
      prlt_pkg::OP_TICK: begin
        // seconds, saturating
        if (sec_q != '1) begin
          sec_d = sec_q + prlt_pkg::SecW'(1);
        end
        // status period; wrap of the counter also counts as due
        status_d = status_q + prlt_pkg::StatusW'(1);
        if (status_d >= cfg_i.status_interval || status_d == '0) begin
          status_d = '0;
          due      = 1'b1;
        end
        // run time and automatic stop
        if (pump_q) begin
          if (run_q != '1) begin
            run_d = run_q + prlt_pkg::RunW'(1);
          end
          if (run_d >= cfg_i.run_limit || reservoir_empty_i) begin
            pump_d      = 1'b0;
            run_d       = '0;
            last_stop_d = sec_d;
            lockout_d   = cfg_i.lockout_period;
          end
        end
        // lockout counts down after any stop in this tick
        if (lockout_d != '0) begin
          lockout_d = lockout_d - prlt_pkg::LockoutW'(1);
        end
      end
      prlt_pkg::OP_START: begin
        if (lockout_q == '0 && !pump_q && !reservoir_empty_i) begin
          pump_d = 1'b1;
          run_d  = '0;
        end
      end
      prlt_pkg::OP_STOP: begin
        // recorded even when already off
        pump_d      = 1'b0;
        run_d       = '0;
        last_stop_d = sec_q;
        lockout_d   = cfg_i.lockout_period;
      end
      default: ;
    endcase
  end

  // Result of this transaction
  always_comb begin
    res_o.pump_running   = pump_d;
    res_o.status_due     = due;
    res_o.idle_seconds   = pump_d ? '0 : sec_d - last_stop_d;
    res_o.lockout_active = (lockout_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q       <= '0;
      last_stop_q <= '0;
      status_q    <= '0;
      run_q       <= '0;
      lockout_q   <= '0;
      pump_q      <= 1'b0;
    end else if (en_i) begin
      sec_q       <= sec_d;
      last_stop_q <= last_stop_d;
      status_q    <= status_d;
      run_q       <= run_d;
      lockout_q   <= lockout_d;
      pump_q      <= pump_d;
    end
  end

endmodule

### sv/prlt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prlt_checker
// Port-level checks for the pump run-limit and lockout timer.
// ----------------------------------------------------------------------------
module prlt_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      pump_running_o,
  input logic                      status_due_o,
  input logic [prlt_pkg::SecW-1:0] idle_seconds_o,
  input logic                      lockout_active_o
);

  // A stalled result stays offered and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable(pump_running_o) && $stable(status_due_o) &&
      $stable(idle_seconds_o) && $stable(lockout_active_o))
    else $error("result changed while stalled");

  // Idle time reads zero while the pump runs
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pump_running_o |-> idle_seconds_o == '0)
    else $error("idle seconds non-zero while pump runs");

  // A running pump never shows an active lockout: a start needs it expired, and a stop turns the pump off
  a_no_run_in_lockout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pump_running_o |-> !lockout_active_o)
    else $error("pump running during lockout");

endmodule

bind pump_run_limit_lockout_timer_top prlt_checker u_prlt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .pump_running_o   (pump_running_o),
  .status_due_o     (status_due_o),
  .idle_seconds_o   (idle_seconds_o),
  .lockout_active_o (lockout_active_o)
);
